[sv/transition_dipole_accumulator_defines.svh]
// assertion macros shared by the transition dipole accumulator rtl
// no dependencies; taken in by the top level
`ifndef TRANSITION_DIPOLE_ACCUMULATOR_DEFINES_SVH
`define TRANSITION_DIPOLE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, cleared while reset is low
`define TDA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, cleared while reset is low
`define TDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tda_pkg.sv]
// shared constants and types of the transition dipole accumulator
// no dependencies; compiled first
`timescale 1ns / 1ps

package tda_pkg;

    localparam int COORD_W    = 16;
    localparam int VOL_W      = 16;
    localparam int DIP_W      = 48;
    localparam int OSC_W      = 63;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPINOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'd1;
    localparam logic [VOL_W-1:0] VOL_RESET = 16'hFFFF;

    // queue between front and back
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_LVL_W    = 3;

    // six sums: x, y, z real then x, y, z imaginary
    localparam int N_SUM      = 6;
    localparam int SUM_IDX_W  = 3;
    localparam int N_RE_SUM   = 3;

    // scaled dipole limits
    localparam logic [DIP_W-1:0] DIP_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [DIP_W-1:0] DIP_NEG_LIM = 48'h8000_0000_0000;

    // sum of squares, done in half-word partial products
    localparam int SQ_HALF_W  = 24;
    localparam int OSC_ACC_W  = 97;
    localparam int OSC_SHIFT  = 24;

    typedef struct packed {
        logic                 empty;
        logic [Q_LVL_W-1:0]   level;
    } t_q_stat;

endpackage

[sv/tda_in_if.sv]
// grid point channel: valid, ready and one point's samples and coordinates
// depends on tda_pkg
`timescale 1ns / 1ps

interface tda_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    import tda_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_WIDTH-1:0]  a_up_re;
    logic signed [SAMPLE_WIDTH-1:0]  a_up_im;
    logic signed [SAMPLE_WIDTH-1:0]  a_dn_re;
    logic signed [SAMPLE_WIDTH-1:0]  a_dn_im;
    logic signed [SAMPLE_WIDTH-1:0]  h_up_re;
    logic signed [SAMPLE_WIDTH-1:0]  h_up_im;
    logic signed [SAMPLE_WIDTH-1:0]  h_dn_re;
    logic signed [SAMPLE_WIDTH-1:0]  h_dn_im;
    logic signed [COORD_W-1:0]       coord_x;
    logic signed [COORD_W-1:0]       coord_y;
    logic signed [COORD_W-1:0]       coord_z;
    logic                            last_point;

    modport source (
        output valid, a_up_re, a_up_im, a_dn_re, a_dn_im,
               h_up_re, h_up_im, h_dn_re, h_dn_im,
               coord_x, coord_y, coord_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, a_up_re, a_up_im, a_dn_re, a_dn_im,
               h_up_re, h_up_im, h_dn_re, h_dn_im,
               coord_x, coord_y, coord_z, last_point,
        output ready
    );

endinterface

[sv/tda_out_if.sv]
// result channel: valid, ready, six scaled dipole sums, strength and flag
// depends on tda_pkg
`timescale 1ns / 1ps

interface tda_out_if;
    import tda_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIP_W-1:0]  dip_x_re;
    logic signed [DIP_W-1:0]  dip_y_re;
    logic signed [DIP_W-1:0]  dip_z_re;
    logic signed [DIP_W-1:0]  dip_x_im;
    logic signed [DIP_W-1:0]  dip_y_im;
    logic signed [DIP_W-1:0]  dip_z_im;
    logic [OSC_W-1:0]         osc_strength;
    logic                     saturated;

    modport source (
        output valid, dip_x_re, dip_y_re, dip_z_re,
               dip_x_im, dip_y_im, dip_z_im, osc_strength, saturated,
        input  ready
    );

    modport sink (
        input  valid, dip_x_re, dip_y_re, dip_z_re,
               dip_x_im, dip_y_im, dip_z_im, osc_strength, saturated,
        output ready
    );

endinterface

[sv/transition_dipole_accumulator.sv]
// top level of the transition dipole accumulator: configuration and wiring
// depends on tda_pkg, tda_in_if, tda_out_if, tda_front, tda_fifo, tda_back
// and the assertion macros in transition_dipole_accumulator_defines.svh
//
// usage
// - i_pt carries one grid point per transfer: eight wavefunction samples,
//   x, y, z and a last_point mark; o_res carries one result per state pair
// - i_cfg_we / i_cfg_idx / i_cfg_data write spinor_mode (index 0) and
//   volume_element (index 1); write them only while the block is idle
// - points stream at one per cycle while the queue has room: products are
//   formed in the front, a four-entry queue decouples it from the back,
//   where the six weighted sums are accumulated with saturation
// - a point marked last starts the finishing sequence in the back: six
//   scaling steps on one 64x16 multiplier, then eighteen half-word squaring
//   steps on one 24x24 multiplier; o_res is loaded once the sequence is done
//   and the result register is free
// - during the finishing sequence the queue is not popped, so it fills and
//   i_pt.ready drops
// - the result register holds its transfer while o_res.ready is low and the
//   back goes on accumulating the next pair until that pair's last point
// - reset clears the sums, the flags, the queue and the result register and
//   sets spinor_mode to 0 and volume_element to all ones
`timescale 1ns / 1ps
`include "transition_dipole_accumulator_defines.svh"

module transition_dipole_accumulator #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tda_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tda_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tda_in_if.sink                          i_pt,
    tda_out_if.source                       o_res
);
    import tda_pkg::*;

    // queue entry: density re and im, three coordinates, mode and last mark
    localparam int ENTRY_W = 2 * (2 * SAMPLE_WIDTH + 2) + 3 * COORD_W + 2;

    // configuration registers
    logic               r_spinor_mode;
    logic [VOL_W-1:0]   r_volume_element;

    // front to queue and queue to back
    logic               w_push;
    logic [ENTRY_W-1:0] w_push_data;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_q_data;
    t_q_stat            w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spinor_mode    <= 1'b0;
            r_volume_element <= VOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SPINOR: r_spinor_mode    <= i_cfg_data[0];
                CFG_VOLUME: r_volume_element <= i_cfg_data[VOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // product stage and density sums; stalls on queue credit only
    tda_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (i_pt),
        .i_spin       (r_spinor_mode),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // decoupling queue, first word falls through
    tda_fifo #(
        .WIDTH    (ENTRY_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_data),
        .i_pop    (w_pop),
        .o_data   (w_q_data),
        .o_stat   (w_q_stat)
    );

    // coordinate weighting, saturating sums, scaling, squares, result register
    tda_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (w_q_stat),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .i_dv         (r_volume_element),
        .o_res        (o_res)
    );

    // queue credit must never let a transfer land in a full queue
    `TDA_ASSERT(a_q_no_overflow, i_clk, i_rst_n, w_push, (w_q_stat.level != Q_LVL_W'(Q_DEPTH)) || w_pop, "queue overflow")
    // the back only pops what is there
    `TDA_ASSERT(a_q_no_underflow, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")
    // a pushed entry is visible to the back on the next cycle
    `TDA_ASSERT_NEXT(a_q_push_seen, i_clk, i_rst_n, w_push, !w_q_stat.empty, "pushed entry lost")
    // all-zero dipole fields give zero strength
    `TDA_ASSERT(a_zero_dip_zero_osc, i_clk, i_rst_n, o_res.valid && (o_res.dip_x_re == '0) && (o_res.dip_y_re == '0) && (o_res.dip_z_re == '0) && (o_res.dip_x_im == '0) && (o_res.dip_y_im == '0) && (o_res.dip_z_im == '0), o_res.osc_strength == '0, "strength without dipole")

endmodule

[sv/tda_front.sv]
// front end: takes grid points, forms the overlap density and queues it
// depends on tda_pkg and tda_in_if
`timescale 1ns / 1ps

module tda_front #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int ENTRY_W = 2 * (2 * SAMPLE_WIDTH + 2) + 3 * tda_pkg::COORD_W + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tda_in_if.sink               i_pt,
    input  logic                 i_spin,
    input  tda_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output logic [ENTRY_W-1:0]   o_push_data
);
    import tda_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int DENS_W = PROD_W + 2;

    logic                        w_accept;
    logic signed [PROD_W-1:0]    w_m [8];
    logic signed [DENS_W-1:0]    w_re;
    logic signed [DENS_W-1:0]    w_im;

    logic                        r_v;
    logic signed [PROD_W-1:0]    r_p [8];
    logic signed [COORD_W-1:0]   r_x;
    logic signed [COORD_W-1:0]   r_y;
    logic signed [COORD_W-1:0]   r_z;
    logic                        r_spin;
    logic                        r_last;

    // room for the point in flight and the new one
    assign i_pt.ready = (i_q_stat.level + Q_LVL_W'(r_v)) < Q_LVL_W'(Q_DEPTH);
    assign w_accept   = i_pt.valid && i_pt.ready;

    // real part terms, then imaginary part terms
    assign w_m[0] = i_pt.a_up_re * i_pt.h_up_re;
    assign w_m[1] = i_pt.a_up_im * i_pt.h_up_im;
    assign w_m[2] = i_pt.a_dn_re * i_pt.h_dn_re;
    assign w_m[3] = i_pt.a_dn_im * i_pt.h_dn_im;
    assign w_m[4] = i_pt.a_up_im * i_pt.h_up_re;
    assign w_m[5] = i_pt.a_dn_im * i_pt.h_dn_re;
    assign w_m[6] = i_pt.a_up_re * i_pt.h_up_im;
    assign w_m[7] = i_pt.a_dn_re * i_pt.h_dn_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= w_accept;
        end
    end

    // scalar points keep only the up-real product
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p[0] <= w_m[0];
            for (int k = 1; k < 8; k++) begin
                r_p[k] <= i_spin ? w_m[k] : '0;
            end
            r_x    <= i_pt.coord_x;
            r_y    <= i_pt.coord_y;
            r_z    <= i_pt.coord_z;
            r_spin <= i_spin;
            r_last <= i_pt.last_point;
        end
    end

    assign w_re = DENS_W'(r_p[0]) + DENS_W'(r_p[1]) + DENS_W'(r_p[2]) + DENS_W'(r_p[3]);
    assign w_im = DENS_W'(r_p[4]) + DENS_W'(r_p[5]) - DENS_W'(r_p[6]) - DENS_W'(r_p[7]);

    assign o_push      = r_v;
    assign o_push_data = {w_re, w_im, r_x, r_y, r_z, r_spin, r_last};

endmodule

[sv/tda_fifo.sv]
// short first-word-fall-through queue between front and back
// depends on tda_pkg
`timescale 1ns / 1ps

module tda_fifo #(
    parameter int WIDTH = 118
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output tda_pkg::t_q_stat     o_stat
);
    import tda_pkg::*;

    logic [WIDTH-1:0]    r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_LVL_W-1:0]  r_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_lvl <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_lvl <= r_lvl + Q_LVL_W'(i_push) - Q_LVL_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.empty = (r_lvl == '0);
    assign o_stat.level = r_lvl;

endmodule

[sv/tda_back.sv]
// back end: weights densities by coordinates, accumulates, scales and squares
// depends on tda_pkg and tda_out_if
`timescale 1ns / 1ps

module tda_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 64,
    localparam int ENTRY_W = 2 * (2 * SAMPLE_WIDTH + 2) + 3 * tda_pkg::COORD_W + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tda_pkg::t_q_stat           i_q_stat,
    input  logic [ENTRY_W-1:0]         i_q_data,
    output logic                       o_pop,
    input  logic [tda_pkg::VOL_W-1:0]  i_dv,
    tda_out_if.source                  o_res
);
    import tda_pkg::*;

    localparam int DENS_W    = 2 * SAMPLE_WIDTH + 2;
    localparam int TERM_W    = DENS_W + COORD_W;
    localparam int SUM_W     = ((ACC_WIDTH > TERM_W) ? ACC_WIDTH : TERM_W) + 1;
    localparam int MAGP_W    = ACC_WIDTH + VOL_W;
    localparam int DIP_SHIFT = 2 * SAMPLE_WIDTH - 2;
    localparam int HI_W      = SUM_W - ACC_WIDTH + 1;

    localparam int Z_LSB  = 2;
    localparam int Y_LSB  = Z_LSB + COORD_W;
    localparam int X_LSB  = Y_LSB + COORD_W;
    localparam int IM_LSB = X_LSB + COORD_W;
    localparam int RE_LSB = IM_LSB + DENS_W;

    localparam logic [ACC_WIDTH-1:0] ACC_MAX_V = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN_V = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    localparam logic [1:0] S_ACC   = 2'd0;
    localparam logic [1:0] S_SCALE = 2'd1;
    localparam logic [1:0] S_SQ    = 2'd2;
    localparam logic [1:0] S_LOAD  = 2'd3;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    localparam logic [SUM_IDX_W-1:0] IDX_LAST = SUM_IDX_W'(N_SUM - 1);

    // queue entry fields
    logic signed [DENS_W-1:0]   w_re;
    logic signed [DENS_W-1:0]   w_im;
    logic signed [COORD_W-1:0]  w_x;
    logic signed [COORD_W-1:0]  w_y;
    logic signed [COORD_W-1:0]  w_z;
    logic signed [TERM_W-1:0]   w_t [N_SUM];

    // product stage
    logic                       r_a_v;
    logic                       r_a_last;
    logic                       r_a_spin;
    logic signed [TERM_W-1:0]   r_t [N_SUM];

    // accumulators
    logic signed [ACC_WIDTH-1:0] r_acc [N_SUM];
    logic signed [SUM_W-1:0]     w_sum [N_SUM];
    logic [HI_W-1:0]             w_hi  [N_SUM];
    logic [ACC_WIDTH-1:0]        w_nacc [N_SUM];
    logic [N_SUM-1:0]            w_lane_sat;
    logic                        r_sat_seen;

    // sequencer
    logic [1:0]                  r_state;
    logic [SUM_IDX_W-1:0]        r_cnt;
    logic [1:0]                  r_part;
    logic                        r_spin_fin;

    // scaling
    logic signed [ACC_WIDTH-1:0] w_sel;
    logic                        w_use;
    logic                        w_neg;
    logic [ACC_WIDTH-1:0]        w_mag;
    logic                        r_sc_v;
    logic                        r_sc_neg;
    logic [SUM_IDX_W-1:0]        r_sc_idx;
    logic [MAGP_W-1:0]           r_sc_prod;
    logic [MAGP_W-1:0]           w_q;
    logic [DIP_W-1:0]            w_lim;
    logic                        w_over;
    logic [DIP_W-1:0]            w_qm;
    logic [DIP_W-1:0]            r_mag [N_SUM];
    logic [DIP_W-1:0]            r_dip [N_SUM];

    // sum of squares
    logic [DIP_W-1:0]            w_sq_m;
    logic [SQ_HALF_W-1:0]        w_opa;
    logic [SQ_HALF_W-1:0]        w_opb;
    logic                        r_sq_v;
    logic [1:0]                  r_sq_part;
    logic [2*SQ_HALF_W-1:0]      r_sq_prod;
    logic [OSC_ACC_W-1:0]        w_addend;
    logic [OSC_ACC_W-1:0]        r_osc;
    logic                        w_osc_sat;

    // result register
    logic                        w_load;
    logic                        r_out_v;
    logic [DIP_W-1:0]            r_out_dip [N_SUM];
    logic [OSC_W-1:0]            r_out_osc;
    logic                        r_out_sat;

    assign w_re = i_q_data[RE_LSB +: DENS_W];
    assign w_im = i_q_data[IM_LSB +: DENS_W];
    assign w_x  = i_q_data[X_LSB +: COORD_W];
    assign w_y  = i_q_data[Y_LSB +: COORD_W];
    assign w_z  = i_q_data[Z_LSB +: COORD_W];

    assign w_t[0] = w_re * w_x;
    assign w_t[1] = w_re * w_y;
    assign w_t[2] = w_re * w_z;
    assign w_t[3] = w_im * w_x;
    assign w_t[4] = w_im * w_y;
    assign w_t[5] = w_im * w_z;

    // no pops from the last point until its result is handed over
    assign o_pop = (r_state == S_ACC) && !i_q_stat.empty && !(r_a_v && r_a_last);

    always_comb begin
        for (int k = 0; k < N_SUM; k++) begin
            w_sum[k] = SUM_W'(r_acc[k]) + SUM_W'(r_t[k]);
            w_hi[k]  = w_sum[k][SUM_W-1:ACC_WIDTH-1];
            if ((w_hi[k] == '0) || (w_hi[k] == '1)) begin
                w_nacc[k]     = w_sum[k][ACC_WIDTH-1:0];
                w_lane_sat[k] = 1'b0;
            end else begin
                w_nacc[k]     = w_sum[k][SUM_W-1] ? ACC_MIN_V : ACC_MAX_V;
                w_lane_sat[k] = 1'b1;
            end
        end
    end

    // magnitude of the selected sum, imaginary ones zero in scalar mode
    assign w_sel = r_acc[r_cnt];
    assign w_use = (r_cnt < SUM_IDX_W'(N_RE_SUM)) || r_spin_fin;
    assign w_neg = w_use && w_sel[ACC_WIDTH-1];
    assign w_mag = !w_use ? '0 : (w_neg ? -w_sel : w_sel);

    assign w_q    = r_sc_prod >> DIP_SHIFT;
    assign w_lim  = r_sc_neg ? DIP_NEG_LIM : DIP_POS_LIM;
    assign w_over = w_q > MAGP_W'(w_lim);
    assign w_qm   = w_over ? w_lim : w_q[DIP_W-1:0];

    // square of a 48 bit magnitude from three half-word products
    assign w_sq_m = r_mag[r_cnt];
    always_comb begin
        case (r_part)
            PART_LL: begin
                w_opa = w_sq_m[SQ_HALF_W-1:0];
                w_opb = w_sq_m[SQ_HALF_W-1:0];
            end
            PART_HL: begin
                w_opa = w_sq_m[2*SQ_HALF_W-1:SQ_HALF_W];
                w_opb = w_sq_m[SQ_HALF_W-1:0];
            end
            PART_HH: begin
                w_opa = w_sq_m[2*SQ_HALF_W-1:SQ_HALF_W];
                w_opb = w_sq_m[2*SQ_HALF_W-1:SQ_HALF_W];
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    always_comb begin
        case (r_sq_part)
            PART_LL: w_addend = OSC_ACC_W'(r_sq_prod);
            PART_HL: w_addend = OSC_ACC_W'(r_sq_prod) << (SQ_HALF_W + 1);
            PART_HH: w_addend = OSC_ACC_W'(r_sq_prod) << (2 * SQ_HALF_W);
            default: w_addend = '0;
        endcase
    end

    assign w_osc_sat = (r_osc[OSC_ACC_W-1:OSC_SHIFT+OSC_W] != '0);
    assign w_load    = (r_state == S_LOAD) && !r_sq_v && (!r_out_v || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_ACC;
            r_cnt      <= '0;
            r_part     <= PART_LL;
            r_a_v      <= 1'b0;
            r_sc_v     <= 1'b0;
            r_sq_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_sat_seen <= 1'b0;
            for (int k = 0; k < N_SUM; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            r_a_v  <= o_pop;
            r_sc_v <= (r_state == S_SCALE);
            r_sq_v <= (r_state == S_SQ);

            if (r_a_v) begin
                for (int k = 0; k < N_SUM; k++) begin
                    r_acc[k] <= w_nacc[k];
                end
            end

            if (w_load) begin
                r_sat_seen <= 1'b0;
                for (int k = 0; k < N_SUM; k++) begin
                    r_acc[k] <= '0;
                end
            end else begin
                r_sat_seen <= r_sat_seen | (r_a_v & (|w_lane_sat)) | (r_sc_v & w_over);
            end

            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_ACC: begin
                    if (r_a_v && r_a_last) begin
                        r_state <= S_SCALE;
                        r_cnt   <= '0;
                    end
                end
                S_SCALE: begin
                    if (r_cnt == IDX_LAST) begin
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                        r_part  <= PART_LL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQ: begin
                    if (r_part == PART_HH) begin
                        r_part <= PART_LL;
                        if (r_cnt == IDX_LAST) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end else begin
                        r_part <= r_part + 1'b1;
                    end
                end
                S_LOAD: begin
                    if (w_load) begin
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_last <= i_q_data[0];
            r_a_spin <= i_q_data[1];
            for (int k = 0; k < N_SUM; k++) begin
                r_t[k] <= w_t[k];
            end
        end

        if ((r_state == S_ACC) && r_a_v && r_a_last) begin
            r_spin_fin <= r_a_spin;
            r_osc      <= '0;
        end else if (r_sq_v) begin
            r_osc <= r_osc + w_addend;
        end

        if (r_state == S_SCALE) begin
            r_sc_prod <= w_mag * i_dv;
            r_sc_neg  <= w_neg;
            r_sc_idx  <= r_cnt;
        end

        if (r_sc_v) begin
            r_mag[r_sc_idx] <= w_qm;
            r_dip[r_sc_idx] <= r_sc_neg ? -w_qm : w_qm;
        end

        if (r_state == S_SQ) begin
            r_sq_prod <= w_opa * w_opb;
            r_sq_part <= r_part;
        end

        if (w_load) begin
            for (int k = 0; k < N_SUM; k++) begin
                r_out_dip[k] <= r_dip[k];
            end
            r_out_osc <= w_osc_sat ? '1 : r_osc[OSC_SHIFT+OSC_W-1:OSC_SHIFT];
            r_out_sat <= r_sat_seen | w_osc_sat;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.dip_x_re     = r_out_dip[0];
    assign o_res.dip_y_re     = r_out_dip[1];
    assign o_res.dip_z_re     = r_out_dip[2];
    assign o_res.dip_x_im     = r_out_dip[3];
    assign o_res.dip_y_im     = r_out_dip[4];
    assign o_res.dip_z_im     = r_out_dip[5];
    assign o_res.osc_strength = r_out_osc;
    assign o_res.saturated    = r_out_sat;

endmodule

[tb/transition_dipole_accumulator_test.sv]
// self-checking bench for the transition dipole accumulator: random and directed grid points
// depends on tda_pkg, tda_in_if, tda_out_if and the transition_dipole_accumulator rtl
`timescale 1ns / 1ps

module transition_dipole_accumulator_test;
    import tda_pkg::*;

    localparam int SAMPLE_W   = 16;
    localparam int DIP_SHIFT  = 2 * SAMPLE_W - 2;
    localparam int DRAIN_WAIT = 40;     // covers the finishing sequence plus the queue
    localparam int HOLD_LEN   = 300;
    localparam longint ACC_HI = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = 64'h8000_0000_0000_0000;

    // one grid point as it travels on the input channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a_up_re;
        logic signed [SAMPLE_W-1:0] a_up_im;
        logic signed [SAMPLE_W-1:0] a_dn_re;
        logic signed [SAMPLE_W-1:0] a_dn_im;
        logic signed [SAMPLE_W-1:0] h_up_re;
        logic signed [SAMPLE_W-1:0] h_up_im;
        logic signed [SAMPLE_W-1:0] h_dn_re;
        logic signed [SAMPLE_W-1:0] h_dn_im;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic                       last_point;
    } point_t;

    // one emitted dipole result: x, y, z real then x, y, z imaginary
    typedef struct packed {
        logic [N_SUM-1:0][DIP_W-1:0] dip;
        logic [OSC_W-1:0]            osc;
        logic                        sat;
    } dipole_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tda_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) pt_if ();
    tda_out_if res_if ();

    transition_dipole_accumulator #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .ACC_WIDTH   (64)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_pt      (pt_if),
        .o_res     (res_if)
    );

    // points waiting to be offered, dipoles waiting to come out
    point_t  pending_pts [$];
    dipole_t expected_dipoles [$];
    int      mismatch_count = 0;

    // predictor state: register copies, the six running moments and the clip flag
    bit             model_spinor = 1'b0;
    logic [VOL_W-1:0] model_dv   = VOL_RESET;
    longint         moment_sum [N_SUM];
    bit             sum_clipped = 1'b0;

    // idling controls set per phase by the stimulus
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;
    int hold_left  = 0;
    int tx_gap     = 0;
    int rx_gap     = 0;

    point_t cur_pt;

    string dip_name [N_SUM] = '{"dip_x_re", "dip_y_re", "dip_z_re",
                                "dip_x_im", "dip_y_im", "dip_z_im"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL transition_dipole_accumulator");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // signed add that clips at the 64-bit limits and remembers it did
    function automatic longint clip_add(input longint acc, input longint term);
        logic [64:0] s;
        s = {acc[63], acc} + {term[63], term};
        if (s[64] != s[63]) begin
            sum_clipped = 1'b1;
            return s[64] ? ACC_LO : ACC_HI;
        end
        return s[63:0];
    endfunction

    // magnitude times dv, truncated toward zero, sign put back, clipped to 48 bits
    // top bit of the return value flags the clip
    function automatic logic [DIP_W:0] scale_moment(input longint acc,
                                                    input logic [VOL_W-1:0] dv);
        logic [63:0]      mag;
        logic [127:0]     prod;
        logic [127:0]     q;
        logic [DIP_W-1:0] lim;
        bit               neg;
        neg  = acc[63];
        mag  = neg ? (64'd0 - acc) : acc;
        prod = {64'd0, mag} * {112'd0, dv};
        q    = prod >> DIP_SHIFT;
        lim  = neg ? DIP_NEG_LIM : DIP_POS_LIM;
        if (q > {80'd0, lim})
            return {1'b1, neg ? -lim : lim};
        return {1'b0, neg ? -q[DIP_W-1:0] : q[DIP_W-1:0]};
    endfunction

    // fold one accepted point into the moments; on the last point queue the dipole
    function automatic void accumulate_point(input point_t p);
        longint           re;
        longint           im;
        longint           crd [3];
        logic [127:0]     sq;
        logic [DIP_W:0]   scaled;
        logic [DIP_W-1:0] mag;
        dipole_t          r;
        bit               clip;
        int               k;
        crd[0] = p.coord_x;
        crd[1] = p.coord_y;
        crd[2] = p.coord_z;
        re = longint'(p.a_up_re) * longint'(p.h_up_re);
        if (model_spinor) begin
            im = longint'(p.a_up_im) * longint'(p.h_up_re)
               + longint'(p.a_dn_im) * longint'(p.h_dn_re)
               - longint'(p.a_up_re) * longint'(p.h_up_im)
               - longint'(p.a_dn_re) * longint'(p.h_dn_im);
            re += longint'(p.a_up_im) * longint'(p.h_up_im)
                + longint'(p.a_dn_re) * longint'(p.h_dn_re)
                + longint'(p.a_dn_im) * longint'(p.h_dn_im);
            for (k = 0; k < 3; k++)
                moment_sum[N_RE_SUM + k] = clip_add(moment_sum[N_RE_SUM + k], im * crd[k]);
        end
        for (k = 0; k < 3; k++)
            moment_sum[k] = clip_add(moment_sum[k], re * crd[k]);
        if (!p.last_point)
            return;

        // imaginary fields only where the last point is a spinor one
        clip = sum_clipped;
        r    = '0;
        for (k = 0; k < N_SUM; k++) begin
            if (k < N_RE_SUM || model_spinor) begin
                scaled   = scale_moment(moment_sum[k], model_dv);
                r.dip[k] = scaled[DIP_W-1:0];
                clip     = clip | scaled[DIP_W];
            end
        end
        sq = '0;
        for (k = 0; k < N_SUM; k++) begin
            mag = r.dip[k][DIP_W-1] ? -r.dip[k] : r.dip[k];
            sq += {80'd0, mag} * {80'd0, mag};
        end
        if (sq[127:87] != 0) begin
            r.osc = '1;
            clip  = 1'b1;
        end else begin
            r.osc = sq[86:OSC_SHIFT];
        end
        r.sat = clip;
        expected_dipoles.push_back(r);
        for (k = 0; k < N_SUM; k++)
            moment_sum[k] = 0;
        sum_clipped = 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // 16-bit word with a bias toward the corners
    function automatic logic [15:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return 16'h8000;
        if (r < 8)  return 16'h7FFF;
        if (r < 10) return 16'hFFFF;
        if (r < 12) return 16'h0000;
        if (r < 13) return 16'h0001;
        return 16'($urandom);
    endfunction

    function automatic point_t random_point(input bit last);
        point_t p;
        p.a_up_re    = pick_word();
        p.a_up_im    = pick_word();
        p.a_dn_re    = pick_word();
        p.a_dn_im    = pick_word();
        p.h_up_re    = pick_word();
        p.h_up_im    = pick_word();
        p.h_dn_re    = pick_word();
        p.h_dn_im    = pick_word();
        p.coord_x    = pick_word();
        p.coord_y    = pick_word();
        p.coord_z    = pick_word();
        p.last_point = last;
        return p;
    endfunction

    // every electron sample equal, every hole sample equal, every coordinate equal
    function automatic point_t flat_point(input logic [15:0] a, input logic [15:0] h,
                                          input logic [15:0] c, input bit last);
        point_t p;
        p.a_up_re    = a;
        p.a_up_im    = a;
        p.a_dn_re    = a;
        p.a_dn_im    = a;
        p.h_up_re    = h;
        p.h_up_im    = h;
        p.h_dn_re    = h;
        p.h_dn_im    = h;
        p.coord_x    = c;
        p.coord_y    = c;
        p.coord_z    = c;
        p.last_point = last;
        return p;
    endfunction

    // near full scale everywhere, all of one sign, so the real moments grow without cancelling
    function automatic point_t heavy_point(input bit last);
        point_t p;
        p = flat_point(16'h8000, 16'h8000, 16'h8000, last);
        p.a_up_re[0] = $urandom_range(0, 1);
        p.a_dn_re[0] = $urandom_range(0, 1);
        p.h_up_re[0] = $urandom_range(0, 1);
        p.h_dn_im[0] = $urandom_range(0, 1);
        p.coord_x[0] = $urandom_range(0, 1);
        p.coord_z[0] = $urandom_range(0, 1);
        return p;
    endfunction

    function automatic void push_pair(input int len);
        int i;
        for (i = 0; i < len; i++)
            pending_pts.push_back(random_point(i == len - 1));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_SPINOR)
            model_spinor = data[0];
        else
            model_dv = data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // spinor bit in bit 0, the other bits random since the block ignores them
    task automatic write_mode(input bit spin);
        write_reg(CFG_SPINOR, (16'($urandom) & 16'hFFFE) | 16'(spin));
    endtask

    // every point offered, every dipole out, then time for the back to settle
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_pts.size() != 0 || pt_if.valid || expected_dipoles.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // point driver: a transfer happens when valid and ready are both high
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : point_driver
        point_t nxt;
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
            tx_gap      <= 0;
        end else begin
            if (pt_if.valid && pt_if.ready)
                accumulate_point(cur_pt);
            // slot is free once the current point has gone or none was offered
            if (!pt_if.valid || pt_if.ready) begin
                if (tx_gap != 0) begin
                    pt_if.valid <= 1'b0;
                    tx_gap      <= tx_gap - 1;
                end else if (pending_pts.size() != 0) begin
                    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                        pt_if.valid <= 1'b0;
                        tx_gap      <= pick_gap() - 1;
                    end else begin
                        nxt                = pending_pts.pop_front();
                        cur_pt            <= nxt;
                        pt_if.a_up_re     <= nxt.a_up_re;
                        pt_if.a_up_im     <= nxt.a_up_im;
                        pt_if.a_dn_re     <= nxt.a_dn_re;
                        pt_if.a_dn_im     <= nxt.a_dn_im;
                        pt_if.h_up_re     <= nxt.h_up_re;
                        pt_if.h_up_im     <= nxt.h_up_im;
                        pt_if.h_dn_re     <= nxt.h_dn_re;
                        pt_if.h_dn_im     <= nxt.h_dn_im;
                        pt_if.coord_x     <= nxt.coord_x;
                        pt_if.coord_y     <= nxt.coord_y;
                        pt_if.coord_z     <= nxt.coord_z;
                        pt_if.last_point  <= nxt.last_point;
                        pt_if.valid       <= 1'b1;
                    end
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off on the result side, started once by the stimulus
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result receiver: random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_gap       <= 0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
        end else if (rx_gap != 0) begin
            res_if.ready <= 1'b0;
            rx_gap       <= rx_gap - 1;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            res_if.ready <= 1'b0;
            rx_gap       <= pick_gap() - 1;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // result monitor: each transfer against the oldest expected dipole
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : dipole_monitor
        dipole_t want;
        dipole_t got;
        int      k;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_dipoles.size() == 0) begin
                $display("%0t: unexpected result transfer, osc %h", $time, res_if.osc_strength);
                mismatch_count++;
            end else begin
                want       = expected_dipoles.pop_front();
                got.dip[0] = res_if.dip_x_re;
                got.dip[1] = res_if.dip_y_re;
                got.dip[2] = res_if.dip_z_re;
                got.dip[3] = res_if.dip_x_im;
                got.dip[4] = res_if.dip_y_im;
                got.dip[5] = res_if.dip_z_im;
                got.osc    = res_if.osc_strength;
                got.sat    = res_if.saturated;
                for (k = 0; k < N_SUM; k++) begin
                    if (got.dip[k] !== want.dip[k]) begin
                        $display("%0t: %s expected %h got %h", $time, dip_name[k],
                                 want.dip[k], got.dip[k]);
                        mismatch_count++;
                    end
                end
                if (got.osc !== want.osc) begin
                    $display("%0t: osc_strength expected %h got %h", $time, want.osc, got.osc);
                    mismatch_count++;
                end
                if (got.sat !== want.sat) begin
                    $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        point_t p;
        int     ph;
        int     n;
        int     len;
        int     r;
        int     k;

        for (k = 0; k < N_SUM; k++)
            moment_sum[k] = 0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        pt_if.valid      = 1'b0;
        pt_if.a_up_re    = '0;
        pt_if.a_up_im    = '0;
        pt_if.a_dn_re    = '0;
        pt_if.a_dn_im    = '0;
        pt_if.h_up_re    = '0;
        pt_if.h_up_im    = '0;
        pt_if.h_dn_re    = '0;
        pt_if.h_dn_im    = '0;
        pt_if.coord_x    = '0;
        pt_if.coord_y    = '0;
        pt_if.coord_z    = '0;
        pt_if.last_point = 1'b0;
        res_if.ready     = 1'b0;
        cur_pt           = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // scalar mode and full-scale dv straight out of reset
        pending_pts.push_back(flat_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1));
        pending_pts.push_back(flat_point(16'h8000, 16'h8000, 16'h8000, 1'b1));
        pending_pts.push_back(flat_point(16'h8000, 16'h7FFF, 16'h8000, 1'b1));
        wait_idle();

        // spinor mode: largest real density, then largest imaginary density
        write_mode(1'b1);
        pending_pts.push_back(flat_point(16'h8000, 16'h8000, 16'h8000, 1'b1));
        p = flat_point(16'h8000, 16'h8000, 16'h7FFF, 1'b1);
        p.h_up_im = 16'h7FFF;
        p.h_dn_im = 16'h7FFF;
        p.coord_y = 16'h8000;
        pending_pts.push_back(p);
        push_pair(3);
        wait_idle();

        // zero volume element gives all-zero fields
        write_reg(CFG_VOLUME, 16'h0000);
        push_pair(2);
        wait_idle();

        // smallest non-zero volume element
        write_reg(CFG_VOLUME, 16'h0001);
        pending_pts.push_back(flat_point(16'h8000, 16'h8000, 16'h8000, 1'b1));
        push_pair(1);
        wait_idle();

        // mode switched part way through a pair, ending in spinor mode
        write_reg(CFG_VOLUME, 16'hFFFF);
        pending_pts.push_back(random_point(1'b0));
        pending_pts.push_back(random_point(1'b0));
        wait_idle();
        write_mode(1'b0);
        pending_pts.push_back(random_point(1'b0));
        wait_idle();
        write_mode(1'b1);
        pending_pts.push_back(random_point(1'b1));
        wait_idle();

        // and ending in scalar mode with imaginary sums left behind
        pending_pts.push_back(random_point(1'b0));
        wait_idle();
        write_mode(1'b0);
        pending_pts.push_back(random_point(1'b1));
        wait_idle();

        // random phases, each with its own register setting and idling pattern
        for (ph = 0; ph < 8; ph++) begin
            write_mode(ph % 3 != 0);
            case (ph % 4)
                0: write_reg(CFG_VOLUME, 16'hFFFF);
                1: write_reg(CFG_VOLUME, 16'h0000);
                2: write_reg(CFG_VOLUME, 16'h0001);
                default: write_reg(CFG_VOLUME, 16'($urandom));
            endcase
            tx_idle_on = (ph % 3 != 0);
            rx_idle_on = (ph % 4 != 1);
            if (ph == 5) begin
                // short pairs at full rate while the receiver holds off, so the queue fills
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                hold_req   = 1'b1;
            end
            n = 0;
            while (n < 130) begin
                r = $urandom_range(0, 99);
                if (ph == 5)
                    len = $urandom_range(1, 2);
                else if (r < 70)
                    len = $urandom_range(1, 6);
                else if (r < 95)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom_range(21, 60);
                push_pair(len);
                n += len;
            end
            wait_idle();
        end

        // one long full-scale pair, enough to clip the oscillator strength
        write_mode(1'b1);
        write_reg(CFG_VOLUME, 16'hFFFF);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        for (k = 0; k < 900; k++)
            pending_pts.push_back(heavy_point(k == 899));
        wait_idle();

        if (mismatch_count == 0 && expected_dipoles.size() == 0) begin
            $display("PASS transition_dipole_accumulator");
        end else begin
            $display("FAIL transition_dipole_accumulator");
        end
        $finish;
    end

endmodule
